@@ rtl/core/pba_pkg.sv @@
// Shared types and constants of the pixel bin averager.
`default_nettype none

package pba_pkg;

  // Fixed field widths
  localparam int BIN_W   = 12;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 48;
  localparam int CFG_W   = 13;

  // Divider step counter covers one step per dividend bit
  localparam int DIV_STEP_W = $clog2(SUM_W);

  // bins_in_use after reset
  localparam logic [CFG_W-1:0] BINS_RESET = 13'd4096;

  // Request function codes
  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic clr_write;
    logic acc_write;
    logic rd_capture;
    logic rd_clear;
    logic div_start;
    logic out_load;
  } pba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic clr_last;
    logic is_read;
    logic acc_drop;
    logic rd_beyond;
    logic cnt_zero;
    logic div_busy;
    logic out_free;
  } pba_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pba_item_if.sv @@
// Input request channel: valid/ready handshake with pixel payload.
`default_nettype none

interface pba_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [pba_pkg::BIN_W-1:0]            bin_index;
  logic signed [pba_pkg::VALUE_W-1:0]   pixel_value;

  modport source (output valid, func, bin_index, pixel_value, input ready);
  modport sink   (input valid, func, bin_index, pixel_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pba_result_if.sv @@
// Result channel: valid/ready handshake with bin average payload.
`default_nettype none

interface pba_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [pba_pkg::BIN_W-1:0]            read_bin;
  logic signed [pba_pkg::VALUE_W-1:0]   average;
  logic                                 bin_empty;
  logic                                 count_overflow;

  modport source (output valid, read_bin, average, bin_empty, count_overflow, input ready);
  modport sink   (input valid, read_bin, average, bin_empty, count_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pba_div.sv @@
// Restoring divider: signed 48-bit sum by unsigned count, one quotient bit per cycle.
`default_nettype none

module pba_div #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [pba_pkg::SUM_W-1:0]    dividend_i,
  input  wire logic [COUNT_BITS-1:0]               divisor_i,
  output logic                                     busy_o,
  output logic signed [pba_pkg::VALUE_W-1:0]       quot_o
);
  import pba_pkg::*;

  logic                  busy_q, busy_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic                  neg_q, neg_d;
  logic [SUM_W-1:0]      dq_q, dq_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;
  logic                  pos_ovf, neg_ovf;
  logic [VALUE_W-1:0]    q_low;

  // One trial subtraction per cycle
  assign trial = {rem_q, dq_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    neg_d  = neg_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = dividend_i[SUM_W-1];
      dq_d   = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      dq_d   = {dq_q[SUM_W-2:0], qbit};
      step_d = step_q + DIV_STEP_W'(1);
      if (step_q == DIV_STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    neg_q  <= neg_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  // Apply sign and saturate the magnitude to the 32-bit range
  assign q_low   = dq_q[VALUE_W-1:0];
  assign pos_ovf = (dq_q[SUM_W-1:VALUE_W-1] != '0);
  assign neg_ovf = (dq_q[SUM_W-1:VALUE_W] != '0) ||
                   (dq_q[VALUE_W-1] && (dq_q[VALUE_W-2:0] != '0));

  always_comb begin
    if (neg_q) begin
      quot_o = neg_ovf ? {1'b1, {(VALUE_W-1){1'b0}}} : VALUE_W'(-q_low);
    end else begin
      quot_o = pos_ovf ? {1'b0, {(VALUE_W-1){1'b1}}} : q_low;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

@@ rtl/core/pba_datapath.sv @@
// Datapath: bin store, item and result registers, config register, divider.
`default_nettype none

module pba_datapath #(
  parameter int MAX_BINS   = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [pba_pkg::CFG_W-1:0]    cfg_wdata_i,
  pba_item_if.sink                          item_i,
  pba_result_if.source                      result_o,
  input  wire pba_pkg::pba_cmd_t            cmd_i,
  output pba_pkg::pba_stat_t                stat_o
);
  import pba_pkg::*;

  localparam int AW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int WORD_W = SUM_W + COUNT_BITS + 1;

  function automatic logic [AW-1:0] to_addr(input logic [BIN_W-1:0] bin);
    logic [AW+BIN_W-1:0] ext;
    ext = {{AW{1'b0}}, bin};
    return ext[AW-1:0];
  endfunction

  function automatic logic in_store(input logic [BIN_W-1:0] bin);
    return (32'(bin) < 32'(MAX_BINS));
  endfunction

  // Bin store: {sum, count, overflow flag}
  logic [WORD_W-1:0] bin_mem [MAX_BINS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [CFG_W-1:0]          bins_q;
  logic [AW-1:0]             clr_q;
  logic                      func_q;
  logic [BIN_W-1:0]          bin_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      empty_q;
  logic                      ovf_q;
  logic                      out_valid_q, out_valid_d;
  logic [BIN_W-1:0]          out_bin_q;
  logic signed [VALUE_W-1:0] out_avg_q;
  logic                      out_empty_q;
  logic                      out_ovf_q;

  logic signed [SUM_W-1:0]   rd_sum;
  logic [COUNT_BITS-1:0]     rd_cnt;
  logic                      rd_ovf;
  logic                      cnt_sat;
  logic                      beyond;
  logic [SUM_W-1:0]          add_ext;
  logic [WORD_W-1:0]         acc_word;
  logic signed [VALUE_W-1:0] div_quot;
  logic                      div_busy;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_RESET;
    end else if (cfg_we_i) begin
      bins_q <= cfg_wdata_i;
    end
  end

  // Clearing pass address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q  <= item_i.func;
      bin_q   <= item_i.bin_index;
      value_q <= item_i.pixel_value;
    end
  end

  // Stored entry fields
  assign rd_sum  = rdata_q[WORD_W-1 -: SUM_W];
  assign rd_cnt  = rdata_q[COUNT_BITS:1];
  assign rd_ovf  = rdata_q[0];
  assign cnt_sat = &rd_cnt;
  assign beyond  = !in_store(bin_q);

  // Accumulate: add or flag a dropped pixel
  assign add_ext  = {{(SUM_W-VALUE_W){value_q[VALUE_W-1]}}, value_q};
  assign acc_word = cnt_sat ? {rd_sum, rd_cnt, 1'b1}
                            : {SUM_W'(rd_sum + add_ext), rd_cnt + COUNT_BITS'(1), rd_ovf};

  // Write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = to_addr(bin_q);
    mem_wdata = acc_word;
    if (cmd_i.clr_write) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.acc_write) begin
      mem_we    = 1'b1;
    end else if (cmd_i.rd_clear) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.load_item) begin
      rdata_q <= bin_mem[to_addr(item_i.bin_index)];
    end
  end

  // Read-out flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_capture) begin
      empty_q <= beyond || (rd_cnt == '0);
      ovf_q   <= !beyond && rd_ovf;
    end
  end

  pba_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_sum),
    .divisor_i  (rd_cnt),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_bin_q   <= bin_q;
      out_avg_q   <= empty_q ? '0 : div_quot;
      out_empty_q <= empty_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign item_i.ready            = cmd_i.in_ready;
  assign result_o.valid          = out_valid_q;
  assign result_o.read_bin       = out_bin_q;
  assign result_o.average        = out_avg_q;
  assign result_o.bin_empty      = out_empty_q;
  assign result_o.count_overflow = out_ovf_q;

  // Status to controller
  assign stat_o.in_valid  = item_i.valid;
  assign stat_o.clr_last  = (clr_q == AW'(MAX_BINS - 1));
  assign stat_o.is_read   = (func_q == FUNC_READ);
  assign stat_o.acc_drop  = ({1'b0, bin_q} >= bins_q) || beyond;
  assign stat_o.rd_beyond = beyond;
  assign stat_o.cnt_zero  = (rd_cnt == '0);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = !out_valid_q || result_o.ready;

endmodule

`default_nettype wire

@@ rtl/core/pba_ctrl.sv @@
// Controller: sequences clearing pass, accumulate, read-out and result hand-off.
`default_nettype none

module pba_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pba_pkg::pba_stat_t   stat_i,
  output pba_pkg::pba_cmd_t         cmd_o
);
  import pba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.is_read) begin
          // fill indices are dropped
          cmd_o.acc_write = !stat_i.acc_drop;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_capture = 1'b1;
          if (stat_i.rd_beyond) begin
            state_d = S_OUT;
          end else begin
            cmd_o.rd_clear = 1'b1;
            if (stat_i.cnt_zero) begin
              state_d = S_OUT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pixel_bin_averager_unit.sv @@
// Top level of the pixel bin averager: controller plus datapath.
// After reset the bin store is cleared one entry per cycle over all MAX_BINS
// entries, during which no request is taken (configuration writes still are).
// An accumulate request takes a registered read of the bin store and then a
// read-modify-write. A read request takes the same registered read, an
// evaluation step and the bit-serial divider (48 quotient bits at one per
// cycle), then the output load; an empty bin skips the divider. The finished
// result sits in an output register so the next request is accepted while it
// waits.
`default_nettype none

module pixel_bin_averager_unit #(
  parameter int MAX_BINS   = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [pba_pkg::CFG_W-1:0]  cfg_wdata_i,
  pba_item_if.sink                        item_i,
  pba_result_if.source                    result_o
);
  import pba_pkg::*;

  pba_cmd_t  cmd;
  pba_stat_t stat;

  pba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pba_datapath #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

@@ rtl/core/pba_checker.sv @@
// Port-level checks of the pixel bin averager and their binding to the top level.
`default_nettype none

module pba_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [pba_pkg::BIN_W-1:0]         out_bin_i,
  input wire logic signed [pba_pkg::VALUE_W-1:0] out_avg_i,
  input wire logic                              out_empty_i,
  input wire logic                              out_ovf_i
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bin_i) &&
      $stable(out_avg_i) && $stable(out_empty_i) && $stable(out_ovf_i))
  else $error("result changed while stalled");

  // One request at a time: ready drops after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
  else $error("request accepted while previous one still in work");

  // A new result is loaded only while no request is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
  else $error("result appeared without a read in work");

  // An empty bin reports zero average and no dropped pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> (out_avg_i == '0) && !out_ovf_i)
  else $error("empty bin with nonzero average or overflow flag");

endmodule

bind pixel_bin_averager_unit pba_checker u_pba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_bin_i   (result_o.read_bin),
  .out_avg_i   (result_o.average),
  .out_empty_i (result_o.bin_empty),
  .out_ovf_i   (result_o.count_overflow)
);

`default_nettype wire

@@ tb/sv/tb_pixel_bin_averager_unit.sv @@
// Self-checking bench for the pixel bin averager: directed and random pixel and read requests.
`default_nettype none

module tb_pixel_bin_averager_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int MAX_BINS      = 4096;
  localparam int COUNT_BITS    = 16;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 64;       // covers a full read plus margin
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 232;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOT_BINS      = 6;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic                       func;
    logic [BIN_W-1:0]           bin;
    logic signed [VALUE_W-1:0]  value;
  } pixel_req_t;

  typedef struct packed {
    logic [BIN_W-1:0]           read_bin;
    logic signed [VALUE_W-1:0]  average;
    logic                       bin_empty;
    logic                       count_overflow;
  } bin_avg_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  pba_item_if   item_bus ();
  pba_result_if result_bus ();

  pixel_bin_averager_unit #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  // Bench copy of the bin store and the bins_in_use register
  logic signed [SUM_W-1:0]  bin_sum     [MAX_BINS];
  logic [COUNT_BITS-1:0]    bin_count   [MAX_BINS];
  logic                     bin_dropped [MAX_BINS];
  logic [CFG_W-1:0]         bins_limit;

  pixel_req_t       request_q[$];
  bin_avg_t         avg_expected_q[$];
  logic [BIN_W-1:0] hot_bins [HOT_BINS];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_start;
  bit item_fired;
  int error_count;
  int request_count;
  int result_count;
  int cfg_count;
  int cycle_count;

  always #HALF_PERIOD clk_i = ~clk_i;

  // Update the bench store for one accepted request; reads queue their average
  task automatic predict_bin_request(input pixel_req_t req);
    longint   sum_wide;
    longint   count_wide;
    longint   quotient;
    bin_avg_t res;
    if (req.func == FUNC_ACC) begin
      // fill indices are dropped; a full bin only records the drop
      if ({1'b0, req.bin} < bins_limit) begin
        if (bin_count[req.bin] == COUNT_FULL) begin
          bin_dropped[req.bin] = 1'b1;
        end else begin
          bin_sum[req.bin]   = bin_sum[req.bin] + SUM_W'(req.value);
          bin_count[req.bin] = bin_count[req.bin] + 1'b1;
        end
      end
    end else begin
      res.read_bin       = req.bin;
      res.count_overflow = bin_dropped[req.bin];
      if (bin_count[req.bin] == '0) begin
        res.average   = '0;
        res.bin_empty = 1'b1;
      end else begin
        sum_wide   = bin_sum[req.bin];
        count_wide = bin_count[req.bin];
        quotient   = sum_wide / count_wide;
        if (quotient > 64'sd2147483647) begin
          quotient = 64'sd2147483647;
        end else if (quotient < -64'sd2147483648) begin
          quotient = -64'sd2147483648;
        end
        res.average   = quotient[VALUE_W-1:0];
        res.bin_empty = 1'b0;
      end
      bin_sum[req.bin]     = '0;
      bin_count[req.bin]   = '0;
      bin_dropped[req.bin] = 1'b0;
      avg_expected_q.push_back(res);
    end
  endtask

  // Request driver: a new request is offered only once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!item_bus.valid || item_fired)) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item_bus.valid       <= 1'b1;
        item_bus.func        <= request_q[0].func;
        item_bus.bin_index   <= request_q[0].bin;
        item_bus.pixel_value <= request_q[0].value;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Request acceptance feeds the predictor
  always @(posedge clk_i) begin
    item_fired = item_bus.valid && item_bus.ready;
    if (item_fired) begin
      predict_bin_request(request_q.pop_front());
      request_count++;
    end
  end

  // Result ready: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    result_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Result monitor: compare against the oldest expected average
  always @(posedge clk_i) begin
    bin_avg_t got;
    bin_avg_t want;
    if (result_bus.valid === 1'b1 && result_bus.ready) begin
      got.read_bin       = result_bus.read_bin;
      got.average        = result_bus.average;
      got.bin_empty      = result_bus.bin_empty;
      got.count_overflow = result_bus.count_overflow;
      result_count++;
      if (avg_expected_q.size() == 0) begin
        $display("%0t: unexpected result bin %0d avg %h empty %b ovf %b", $time,
                 got.read_bin, got.average, got.bin_empty, got.count_overflow);
        error_count++;
      end else begin
        want = avg_expected_q.pop_front();
        if (got.read_bin !== want.read_bin || got.average !== want.average ||
            got.bin_empty !== want.bin_empty || got.count_overflow !== want.count_overflow)
        begin
          $display("%0t: mismatch expected bin %0d avg %h empty %b ovf %b", $time,
                   want.read_bin, want.average, want.bin_empty, want.count_overflow);
          $display("%0t:          actual   bin %0d avg %h empty %b ovf %b", $time,
                   got.read_bin, got.average, got.bin_empty, got.count_overflow);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d requests and %0d results outstanding", $time,
               request_q.size(), avg_expected_q.size());
      $display("tb_pixel_bin_averager_unit NOT OK");
      $finish;
    end
  end

  task automatic queue_req(input logic func, input logic [BIN_W-1:0] bin,
                           input logic [VALUE_W-1:0] value);
    pixel_req_t req;
    req.func  = func;
    req.bin   = bin;
    req.value = value;
    request_q.push_back(req);
  endtask

  // Block is idle once every request is in and every read has come back
  task automatic wait_idle();
    while (request_q.size() != 0 || avg_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bins_limit(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    bins_limit = value;
    cfg_count++;
    @(posedge clk_i);
  endtask

  // Random requests mostly on a few hot bins, including the fill boundary
  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input logic [CFG_W-1:0] limit, input bit squeeze);
    int         top;
    int         i;
    pixel_req_t req;
    write_bins_limit(limit);
    top = (limit > MAX_BINS) ? MAX_BINS : int'(limit);
    hot_bins[0] = '0;
    hot_bins[1] = BIN_W'(top - 1);
    hot_bins[2] = (limit < MAX_BINS) ? BIN_W'(limit) : BIN_W'(MAX_BINS - 1);
    for (i = 3; i < HOT_BINS; i++) begin
      hot_bins[i] = BIN_W'($urandom_range(top - 1));
    end
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      req.func = ($urandom_range(99) < 25) ? FUNC_READ : FUNC_ACC;
      req.bin  = ($urandom_range(99) < 85) ? hot_bins[$urandom_range(HOT_BINS - 1)]
                                            : BIN_W'($urandom());
      case ($urandom_range(9))
        0:       req.value = 32'h7FFF_FFFF;
        1:       req.value = 32'h8000_0000;
        2, 3:    req.value = $urandom_range(16) - 8;
        default: req.value = $urandom();
      endcase
      request_q.push_back(req);
    end
    if (squeeze) begin
      @(negedge clk_i);
      hold_start = 1'b1;
    end
    wait_idle();
  endtask

  initial begin
    int i;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    item_bus.valid       = 1'b0;
    item_bus.func        = FUNC_ACC;
    item_bus.bin_index   = '0;
    item_bus.pixel_value = '0;
    result_bus.ready     = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_left            = 0;
    hold_start           = 1'b0;
    item_fired           = 1'b0;
    error_count          = 0;
    request_count        = 0;
    result_count         = 0;
    cfg_count            = 0;
    cycle_count          = 0;
    bins_limit           = BINS_RESET;
    for (i = 0; i < MAX_BINS; i++) begin
      bin_sum[i]     = '0;
      bin_count[i]   = '0;
      bin_dropped[i] = 1'b0;
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: value extremes, truncation toward zero, empty and cleared bins
    queue_req(FUNC_ACC,  12'd0,   32'h7FFF_FFFF);
    queue_req(FUNC_ACC,  12'd0,   32'h7FFF_FFFF);
    queue_req(FUNC_READ, 12'd0,   32'h0);
    queue_req(FUNC_ACC,  12'hFFF, 32'h8000_0000);
    queue_req(FUNC_ACC,  12'hFFF, 32'hFFFF_FFFF);
    queue_req(FUNC_READ, 12'hFFF, 32'h0);
    queue_req(FUNC_ACC,  12'd7,   32'hFFFF_FFFD);
    queue_req(FUNC_ACC,  12'd7,   32'h0);
    queue_req(FUNC_READ, 12'd7,   32'h0);
    queue_req(FUNC_ACC,  12'd9,   32'h5);
    queue_req(FUNC_ACC,  12'd9,   32'h0);
    queue_req(FUNC_READ, 12'd9,   32'h0);
    queue_req(FUNC_READ, 12'd5,   32'hDEAD_BEEF);
    queue_req(FUNC_READ, 12'd0,   32'h0);
    // accumulate straight into a read of the same bin, then read it again
    queue_req(FUNC_ACC,  12'd1,   32'h0001_8000);
    queue_req(FUNC_READ, 12'd1,   32'h0);
    queue_req(FUNC_READ, 12'd1,   32'h0);
    wait_idle();

    // No bins in use: every pixel is fill
    write_bins_limit('0);
    queue_req(FUNC_ACC,  12'd0, 32'd123);
    queue_req(FUNC_READ, 12'd0, 32'h0);
    wait_idle();

    // One bin in use: bin 1 is fill but can still be read
    write_bins_limit(13'd1);
    queue_req(FUNC_ACC,  12'd0, 32'd10);
    queue_req(FUNC_ACC,  12'd1, 32'd20);
    queue_req(FUNC_READ, 12'd0, 32'h0);
    queue_req(FUNC_READ, 12'd1, 32'h0);
    wait_idle();

    // Random phases under the four idling modes
    run_random_phase(0,  0,  BINS_RESET, 1'b0);
    run_random_phase(61, 0,  CFG_W'($urandom_range(2, 64)), 1'b0);
    run_random_phase(0,  61, CFG_W'($urandom_range(1, MAX_BINS)), 1'b1);
    run_random_phase(35, 35, CFG_W'($urandom_range(MAX_BINS / 2, 8191)), 1'b0);

    $display("Checked %0d bin read-outs from %0d requests over %0d bins_in_use writes,",
             result_count, request_count, cfg_count);
    $display("with fill indices, empty bins, sign extremes and a long result hold-off.");
    if (error_count == 0) begin
      $display("tb_pixel_bin_averager_unit OK");
    end else begin
      $display("tb_pixel_bin_averager_unit NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
